// ----- hdl/mbss_pkg.sv -----
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared types and constants of the masked byte signature scan core.
// ----------------------------------------------------------------------------
package mbss_pkg;

    localparam int PAT_BYTES  = 16;
    localparam int PAT_BITS   = 8 * PAT_BYTES;
    localparam int CARE_BITS  = PAT_BYTES;
    localparam int LEN_BITS   = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int RES_OFF_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd3;

    localparam logic [CARE_BITS-1:0] CARE_RESET = 16'hFFFF;
    localparam logic [LEN_BITS-1:0]  LEN_RESET  = 5'd1;

    typedef struct packed {
        logic [PAT_BITS-1:0]  pattern;
        logic [CARE_BITS-1:0] care;
        logic [LEN_BITS-1:0]  length;
    } mbss_cfg_t;

    typedef struct packed {
        logic                 emit;
        logic                 found;
        logic [RES_OFF_W-1:0] offset;
    } mbss_result_t;

endpackage

// ----- hdl/mbss_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mbss_cfg_regs
// Configuration register file: pattern bytes, care mask and pattern length.
// ----------------------------------------------------------------------------
module mbss_cfg_regs
    import mbss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output mbss_cfg_t             cfg
);

    mbss_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_PATTERN_LOW:  cfg_next.pattern[63:0]   = cfg_wr_data;
                CFG_PATTERN_HIGH: cfg_next.pattern[127:64] = cfg_wr_data;
                CFG_CARE_MASK:    cfg_next.care   = cfg_wr_data[CARE_BITS-1:0];
                CFG_PATTERN_LEN:  cfg_next.length = cfg_wr_data[LEN_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern <= '0;
            cfg_reg.care    <= CARE_RESET;
            cfg_reg.length  <= LEN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/mbss_match.sv -----
// ----------------------------------------------------------------------------
// mbss_match
// Byte window, offset counter and masked compare against the pattern.
// ----------------------------------------------------------------------------
module mbss_match
    import mbss_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   scan_byte,
    input  logic         last_byte,
    input  mbss_cfg_t    cfg,
    output mbss_result_t result
);

    localparam logic [LEN_BITS-1:0]    LEN_MAX = LEN_BITS'(PATTERN_MAX);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    logic [7:0]             window_reg [PATTERN_MAX];
    logic [7:0]             window_next [PATTERN_MAX];
    logic [OFFSET_BITS-1:0] seen_reg, seen_next, seen_inc;
    logic                   reported_reg, reported_next;

    logic [LEN_BITS-1:0]    used_len;
    logic [3:0]             pat_idx [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] pos_ok;
    logic                   overflow, hit;
    logic [OFFSET_BITS-1:0] start;

    always_comb begin
        priority if (cfg.length == '0) begin
            used_len = LEN_BITS'(1);
        end else if (cfg.length > LEN_MAX) begin
            used_len = LEN_MAX;
        end else begin
            used_len = cfg.length;
        end
    end

    // window as it stands once the new byte is shifted in; entry 0 newest
    always_comb begin
        window_next[0] = scan_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            window_next[k] = window_reg[k-1];
        end
    end

    // window entry i lines up with pattern byte used_len-1-i
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pat_idx[i] = 4'(used_len - LEN_BITS'(i) - LEN_BITS'(1));
            pos_ok[i]  = (LEN_BITS'(i) >= used_len) || !cfg.care[pat_idx[i]] ||
                         (window_next[i] == cfg.pattern[8*pat_idx[i] +: 8]);
        end
    end

    assign overflow = (seen_reg == OFF_MAX);
    assign seen_inc = overflow ? seen_reg : seen_reg + OFFSET_BITS'(1);
    assign hit      = !overflow && !reported_reg &&
                      (seen_inc >= OFFSET_BITS'(used_len)) && (&pos_ok);
    assign start    = seen_inc - OFFSET_BITS'(used_len);

    assign result.emit   = hit || (last_byte && !reported_reg);
    assign result.found  = hit;
    assign result.offset = hit ? RES_OFF_W'(start) : '0;

    always_comb begin
        seen_next     = seen_reg;
        reported_next = reported_reg;
        if (step) begin
            if (last_byte) begin
                seen_next     = '0;
                reported_next = 1'b0;
            end else begin
                seen_next     = seen_inc;
                reported_next = reported_reg || hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else begin
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                window_reg[k] <= '0;
            end
        end else if (step) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                window_reg[k] <= last_byte ? 8'h00 : window_next[k];
            end
        end
    end

endmodule

// ----- hdl/masked_byte_signature_scan_core.sv -----
// ----------------------------------------------------------------------------
// masked_byte_signature_scan_core
// Searches a byte stream for a pattern of up to 16 bytes with wildcard bytes.
//
// Input channel (s_): one byte per transaction in s_tdata, s_tlast on the
// final byte of a region. Result channel (m_): at most one transaction per
// region; m_tuser high gives the start offset of the first match in m_tdata,
// m_tuser low on the final byte means the region held no match.
// Configuration: cfg_wr_en writes cfg_wr_data into the register selected by
// cfg_wr_index (pattern low, pattern high, care mask, length); write only
// while no bytes are in flight.
// A byte accepted into the input register passes to the matcher, and its result,
// if any, is registered into the output stage that drives m_. One byte per cycle
// while m_ is not stalled, set by the window shift and parallel masked compare.
// Reset clears the window, offset counter, match flag and both pipeline
// stages; configuration returns to its reset values. When m_tready is low
// with a result pending, the input stage holds and s_tready drops once the
// input register is also occupied.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan_core
    import mbss_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,      // [7:0] scan_byte
    input  logic                  s_tlast,      // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,      // [31:0] match_offset
    output logic                  m_tuser,      // found
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    mbss_cfg_t    cfg;
    mbss_result_t result;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    logic [31:0] out_offset_reg;
    logic       out_found_reg;
    logic       out_free, advance;

    mbss_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    mbss_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .scan_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg),
        .result    (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = advance && result.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && out_free) begin
            out_offset_reg <= result.offset;
            out_found_reg  <= result.found;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = out_found_reg;

endmodule

// ----- hdl/mbss_checker.sv -----
// ----------------------------------------------------------------------------
// mbss_checker
// Port-level checks of the scan core, attached by bind.
// ----------------------------------------------------------------------------
module mbss_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,
    input  logic                  m_tuser
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // not-found result carries a zero offset
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("not-found result with non-zero offset");

    // empty output stage never blocks input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output stage");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind masked_byte_signature_scan_core mbss_checker u_mbss_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the masked byte signature scan core. A short table
// of directed bytes and register writes exercises reset values, wildcards,
// a match on the last byte, short regions and out-of-range lengths. Random
// phases with fresh register settings follow, mostly regions that carry the
// pattern. Results are checked against typed rows, else a local window model.
// ----------------------------------------------------------------------------
module tb;
    import mbss_pkg::*;

    localparam int SETTLE      = 4;
    localparam int QUIET_LIMIT = 5000;
    localparam int NPHASE      = 10;
    localparam int PHASE_BYTES = 30;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;   // register value, or the byte in [7:0]
        logic                  last;
        logic                  typed;
        mbss_result_t          res;
    } dir_row_t;

    localparam mbss_result_t NO_RES = '0;
    localparam mbss_result_t MISS   = '{emit: 1'b1, found: 1'b0, offset: 32'd0};
    localparam int NDIR = 22;

    localparam dir_row_t DIR_TAB [NDIR] = '{
        '{ROW_BYTE, '0, 64'h00, 1'b0, 1'b1, '{1'b1, 1'b1, 32'd0}},
        '{ROW_BYTE, '0, 64'hFF, 1'b1, 1'b1, NO_RES},
        '{ROW_BYTE, '0, 64'h5A, 1'b1, 1'b1, MISS},
        '{ROW_CFG, CFG_PATTERN_LOW, 64'h0000_0074_7865_742E, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_PATTERN_LEN, 64'd5, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_CARE_MASK, 64'h1D, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h41, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h2E, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h00, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h65, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h78, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h74, 1'b1, 1'b1, '{1'b1, 1'b1, 32'd1}},
        '{ROW_BYTE, '0, 64'h2E, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h74, 1'b1, 1'b1, MISS},
        '{ROW_CFG, CFG_CARE_MASK, 64'h0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_PATTERN_LEN, 64'h0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'hFF, 1'b1, 1'b1, '{1'b1, 1'b1, 32'd0}},
        '{ROW_CFG, CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_PATTERN_LEN, 64'h1F, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h00, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h80, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 64'h7F, 1'b1, 1'b1, MISS}
    };

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata      = '0;
    logic                  s_tlast      = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    // model state
    mbss_cfg_t       cfg_shadow = '{pattern: '0, care: CARE_RESET, length: LEN_RESET};
    logic [15:0][7:0] win_q     = '0;
    logic [31:0]      seen_q    = '0;
    logic             reported_q = 1'b0;

    mbss_result_t awaited [$];
    mbss_result_t head_r;
    int           mismatches = 0;
    int           quiet      = 0;
    logic         steady     = 1'b0;

    masked_byte_signature_scan_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int used_len();
        int n;
        n = int'(cfg_shadow.length);
        if (n == 0) n = 1;
        if (n > PAT_BYTES) n = PAT_BYTES;
        return n;
    endfunction

    function automatic mbss_result_t window_scan(logic [7:0] b, logic last);
        int           n;
        logic         sat;
        logic         hit;
        mbss_result_t r;
        n   = used_len();
        sat = (seen_q == '1);
        win_q = {win_q[14:0], b};
        if (!sat) seen_q = seen_q + 1;
        hit = 1'b1;
        for (int j = 0; j < n; j++) begin
            if (cfg_shadow.care[j] && win_q[n-1-j] != cfg_shadow.pattern[8*j +: 8])
                hit = 1'b0;
        end
        r = '0;
        if (!sat && !reported_q && seen_q >= n && hit) begin
            r.emit     = 1'b1;
            r.found    = 1'b1;
            r.offset   = seen_q - n;
            reported_q = 1'b1;
        end else if (last && !reported_q) begin
            r = MISS;
        end
        if (last) begin
            win_q      = '0;
            seen_q     = '0;
            reported_q = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("tb: mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                             input mbss_result_t typed_res);
        mbss_result_t r;
        while (!steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        r = window_scan(b, last);
        if (typed) r = typed_res;
        if (r.emit) awaited.push_back(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // leaves cfg_wr_en high; the caller lowers it after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_PATTERN_LOW:  cfg_shadow.pattern[63:0]   = data;
            CFG_PATTERN_HIGH: cfg_shadow.pattern[127:64] = data;
            CFG_CARE_MASK:    cfg_shadow.care            = data[CARE_BITS-1:0];
            CFG_PATTERN_LEN:  cfg_shadow.length          = data[LEN_BITS-1:0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited.size() == 0) begin
                report_mismatch("result with none awaited", {31'd0, m_tuser}, 32'd0);
            end else begin
                head_r = awaited.pop_front();
                if (m_tuser !== head_r.found)
                    report_mismatch("found", {31'd0, m_tuser}, {31'd0, head_r.found});
                if (m_tdata !== head_r.offset)
                    report_mismatch("match_offset", m_tdata, head_r.offset);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0]  region [64];
        logic [63:0] rnd;
        logic [15:0] care_v;
        logic [4:0]  len_v;
        int          n;
        int          rlen;
        int          pos;
        int          sent;
        int          j;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NDIR; i++) begin
            if (DIR_TAB[i].kind == ROW_CFG) begin
                if (i == 0 || DIR_TAB[i-1].kind != ROW_CFG) drain();
                cfg_write(DIR_TAB[i].idx, DIR_TAB[i].data);
            end else begin
                if (i > 0 && DIR_TAB[i-1].kind == ROW_CFG) cfg_wr_en <= 1'b0;
                push_byte(DIR_TAB[i].data[7:0], DIR_TAB[i].last, DIR_TAB[i].typed,
                          DIR_TAB[i].res);
            end
        end

        for (int ph = 0; ph < NPHASE; ph++) begin
            drain();
            steady = (ph == 5);
            for (int r = 0; r < 2; r++) begin
                rnd = {$urandom, $urandom};
                case ($urandom_range(4))
                    0: rnd = '0;
                    1: rnd = '1;
                    default: ;
                endcase
                cfg_write(r == 0 ? CFG_PATTERN_LOW : CFG_PATTERN_HIGH, rnd);
            end
            case ($urandom_range(3))
                0: care_v = 16'hFFFF;
                1: care_v = 16'h0000;
                default: care_v = 16'($urandom);
            endcase
            case ($urandom_range(5))
                0: len_v = 5'd1;
                1: len_v = 5'd16;
                2: len_v = ($urandom_range(1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
                default: len_v = 5'($urandom_range(1, 16));
            endcase
            rnd = {$urandom, $urandom};
            cfg_write(CFG_CARE_MASK, {rnd[63:16], care_v});
            rnd = {$urandom, $urandom};
            cfg_write(CFG_PATTERN_LEN, {rnd[63:5], len_v});
            cfg_wr_en <= 1'b0;
            n = used_len();

            sent = 0;
            while (sent < PHASE_BYTES) begin
                case ($urandom_range(9))
                    0: rlen = $urandom_range(1, n);
                    1: rlen = $urandom_range(40, 48);
                    default: rlen = $urandom_range(n, n + 12);
                endcase
                for (int k = 0; k < rlen; k++) region[k] = 8'($urandom);
                // plant the pattern, now and then twice or with one bit spoilt
                for (int c = 0; c < 2; c++) begin
                    if ($urandom_range(9) < (c == 0 ? 7 : 3) && rlen >= n) begin
                        pos = $urandom_range(0, rlen - n);
                        for (int q = 0; q < n; q++)
                            if (cfg_shadow.care[q])
                                region[pos+q] = cfg_shadow.pattern[8*q +: 8];
                        if ($urandom_range(3) == 0) begin
                            j = $urandom_range(0, n - 1);
                            region[pos+j] = region[pos+j] ^ (8'h01 << $urandom_range(7));
                        end
                    end
                end
                for (int k = 0; k < rlen; k++)
                    push_byte(region[k], k == rlen - 1, 1'b0, NO_RES);
                sent += rlen;
            end
        end
        steady = 1'b0;

        drain();
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mbss_pkg.sv
hdl/mbss_cfg_regs.sv
hdl/mbss_match.sv
hdl/masked_byte_signature_scan_core.sv
hdl/mbss_checker.sv
tb/tb.sv
